// ===== hw/rtl/msup_pkg.sv =====
package msup_pkg;

    // fixed channel count and field widths
    localparam int MSUP_CHANNELS = 3;
    localparam int ID_W          = 11;
    localparam int CNT_W         = 8;
    localparam int CH_W          = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = ID_W;

    // register reset values
    localparam logic [ID_W-1:0]  ID_RESET     [MSUP_CHANNELS] = '{11'd1184, 11'd928, 11'd1568};
    localparam logic [CNT_W-1:0] PERIOD_RESET [MSUP_CHANNELS] = '{8'd10, 8'd4, 8'd20};
    localparam logic [CNT_W-1:0] FAIL_RESET   = 8'd10;
    localparam logic [CNT_W-1:0] PASS_RESET   = 8'd5;

    // register indexes beyond the per-channel blocks
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_THR = CFG_IDX_W'(2 * MSUP_CHANNELS);
    localparam logic [CFG_IDX_W-1:0] REG_PASS_THR = CFG_IDX_W'(2 * MSUP_CHANNELS + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_CHECK = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REP_NONE = 2'd0,
        REP_FAIL = 2'd1,
        REP_PASS = 2'd2
    } t_report;

    // one accepted input beat as seen by every channel
    typedef struct packed {
        logic            accept;
        logic [1:0]      mode;
        logic [ID_W-1:0] frame_id;
        logic            acc_idle;
        logic            bus_off;
    } t_beat;

endpackage

// ===== hw/rtl/msup_cfg.sv =====
module msup_cfg
    import msup_pkg::*;
#(
    parameter int CHANNELS = MSUP_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [ID_W-1:0]       o_id     [CHANNELS],
    output logic [CNT_W-1:0]      o_period [CHANNELS],
    output logic [CNT_W-1:0]      o_fail_thr,
    output logic [CNT_W-1:0]      o_pass_thr
);

    logic [ID_W-1:0]  r_id     [CHANNELS];
    logic [CNT_W-1:0] r_period [CHANNELS];
    logic [CNT_W-1:0] r_fail_thr;
    logic [CNT_W-1:0] r_pass_thr;

    // per-channel identifier and period registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            if (!i_rst_n) begin
                r_id[i]     <= ID_RESET[i];
                r_period[i] <= PERIOD_RESET[i];
            end else if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_W'(i))
                    r_id[i] <= i_cfg_data[ID_W-1:0];
                if (i_cfg_idx == CFG_IDX_W'(CHANNELS + i))
                    r_period[i] <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    // debounce thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_thr <= FAIL_RESET;
            r_pass_thr <= PASS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FAIL_THR)
                r_fail_thr <= i_cfg_data[CNT_W-1:0];
            if (i_cfg_idx == REG_PASS_THR)
                r_pass_thr <= i_cfg_data[CNT_W-1:0];
        end
    end

    assign o_id       = r_id;
    assign o_period   = r_period;
    assign o_fail_thr = r_fail_thr;
    assign o_pass_thr = r_pass_thr;

endmodule

// ===== hw/rtl/msup_chan.sv =====
module msup_chan
    import msup_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_beat            i_beat,
    input  logic [ID_W-1:0]  i_id,
    input  logic [CNT_W-1:0] i_period,
    input  logic [CNT_W-1:0] i_fail_thr,
    input  logic [CNT_W-1:0] i_pass_thr,
    output t_report          o_report
);

    logic [CNT_W-1:0] r_timer, n_timer;
    logic             r_lost,  n_lost;
    logic [CNT_W-1:0] r_miss,  n_miss;
    logic [CNT_W-1:0] r_seen,  n_seen;
    logic [CNT_W-1:0] miss_base;
    logic [CNT_W-1:0] seen_base;
    t_report          report;

    // counters restart when the opposite one was running
    assign miss_base = (r_seen != '0) ? '0 : r_miss;
    assign seen_base = (r_miss != '0) ? '0 : r_seen;

    // next state of this channel for the accepted beat
    always_comb begin
        n_timer = r_timer;
        n_lost  = r_lost;
        n_miss  = r_miss;
        n_seen  = r_seen;
        report  = REP_NONE;
        if (i_beat.accept) begin
            case (t_mode'(i_beat.mode))
                MODE_TICK: begin
                    if (r_timer != '0)
                        n_timer = r_timer - 1'b1;
                end
                MODE_FRAME: begin
                    if (i_beat.frame_id == i_id)
                        n_lost = 1'b0;
                end
                MODE_CHECK: begin
                    if (!i_beat.acc_idle || i_beat.bus_off) begin
                        n_timer = i_period;
                        n_lost  = 1'b0;
                        n_miss  = '0;
                        n_seen  = '0;
                    end else if (r_timer == '0) begin
                        if (r_lost) begin
                            n_miss = (miss_base == CNT_MAX) ? miss_base : miss_base + 1'b1;
                            n_seen = '0;
                            if (n_miss >= i_fail_thr)
                                report = REP_FAIL;
                        end else begin
                            n_seen = (seen_base == CNT_MAX) ? seen_base : seen_base + 1'b1;
                            n_miss = '0;
                            if (n_seen >= i_pass_thr)
                                report = REP_PASS;
                        end
                        n_timer = i_period;
                        n_lost  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_lost  <= 1'b0;
            r_miss  <= '0;
            r_seen  <= '0;
        end else begin
            r_timer <= n_timer;
            r_lost  <= n_lost;
            r_miss  <= n_miss;
            r_seen  <= n_seen;
        end
    end

    assign o_report = report;

endmodule

// ===== hw/rtl/msup_rpt.sv =====
module msup_rpt
    import msup_pkg::*;
#(
    parameter int CHANNELS = MSUP_CHANNELS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  t_report         i_report [CHANNELS],
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CH_W-1:0] o_channel,
    output logic [1:0]      o_report,
    output logic            o_last
);

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    t_report         r_rep [CHANNELS];
    logic            r_valid;
    logic [CH_W-1:0] r_idx;
    logic            last;
    logic            take;

    assign last   = (r_idx == LAST_CH);
    assign take   = r_valid && !i_stall;
    // a new set of reports may be loaded once the final beat of the old one leaves
    assign o_free = !r_valid || (take && last);

    // report set and read-out position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (last)
                r_valid <= 1'b0;
            else
                r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load)
            r_rep <= i_report;
    end

    assign o_valid   = r_valid;
    assign o_channel = r_idx;
    assign o_report  = r_rep[r_idx];
    assign o_last    = last;

endmodule

// ===== hw/rtl/message_loss_supervisor.sv =====
// Message loss supervisor for three periodic receive identifiers. Each input
// beat is a timer tick, a frame arrival or a check pass. Channel state
// updates at the accepting edge, so ticks and frames flow at one beat per
// cycle and produce no output. A check pass produces three report beats, one
// per channel in channel order with o_last on the final one; they leave from
// a report buffer at one per cycle while i_stall is low. A check pass is held
// off only while the previous check's reports are still queued, so
// back-to-back checks are paced by the single output port. Configuration
// writes are taken at any time through the write port.
module message_loss_supervisor
    import msup_pkg::*;
#(
    parameter int CHANNELS = MSUP_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_mode,
    input  logic [ID_W-1:0]       i_frame_id,
    input  logic                  i_acc_idle,
    input  logic                  i_bus_off,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CH_W-1:0]       o_channel,
    output logic [1:0]            o_report,
    output logic                  o_last
);

    logic [ID_W-1:0]  cfg_id     [CHANNELS];
    logic [CNT_W-1:0] cfg_period [CHANNELS];
    logic [CNT_W-1:0] cfg_fail_thr;
    logic [CNT_W-1:0] cfg_pass_thr;
    t_report          chan_rep   [CHANNELS];
    t_beat            beat;
    logic             rpt_free;
    logic             is_check;

    // configuration registers
    msup_cfg #(
        .CHANNELS (CHANNELS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_id       (cfg_id),
        .o_period   (cfg_period),
        .o_fail_thr (cfg_fail_thr),
        .o_pass_thr (cfg_pass_thr)
    );

    // input handshake
    assign is_check = (t_mode'(i_mode) == MODE_CHECK);
    assign o_stall  = is_check && !rpt_free;

    assign beat.accept   = i_valid && !o_stall;
    assign beat.mode     = i_mode;
    assign beat.frame_id = i_frame_id;
    assign beat.acc_idle = i_acc_idle;
    assign beat.bus_off  = i_bus_off;

    // one supervisor per channel, all updated side by side
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        msup_chan u_chan (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_beat     (beat),
            .i_id       (cfg_id[g]),
            .i_period   (cfg_period[g]),
            .i_fail_thr (cfg_fail_thr),
            .i_pass_thr (cfg_pass_thr),
            .o_report   (chan_rep[g])
        );
    end

    // report buffer and output beats
    msup_rpt #(
        .CHANNELS (CHANNELS)
    ) u_rpt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (beat.accept && is_check),
        .i_report  (chan_rep),
        .o_free    (rpt_free),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_channel (o_channel),
        .o_report  (o_report),
        .o_last    (o_last)
    );

endmodule
